>>> rtl/core/complementary_tilt_filter_assert.svh
// Assertion macros shared by the tilt filter RTL; sampled on clock, off during reset.
`ifndef COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// Same-cycle implication
`define CTF_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CTF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ctf_pkg.sv
package ctf_pkg;

   // Field widths
   localparam int CTF_IN_W     = 16;
   localparam int CTF_OUT_W    = 17;
   localparam int CTF_WEIGHT_W = 16;
   localparam int CTF_STEP_W   = 24;
   localparam int CTF_CSR_W    = 24;

   // CORDIC defaults and table length
   localparam int CTF_CORDIC_STEPS = 16;
   localparam int CTF_ATAN_LEN     = 24;

   // Register reset values
   localparam logic [CTF_WEIGHT_W-1:0] CTF_WEIGHT_RESET = 16'd26214;
   localparam logic [CTF_STEP_W-1:0]   CTF_STEP_RESET   = 24'd16777;

   // Angle limits (Q8.8) and the right angle in Q.16 degrees
   localparam logic signed [CTF_OUT_W-1:0] CTF_ANGLE_MAX  = 17'sd46080;
   localparam logic signed [23:0]          CTF_NINETY_Q16 = 24'sd5898240;
   localparam logic [16:0]                 CTF_WEIGHT_ONE = 17'd32768;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_GYRO_WEIGHT = 1'b0,
      CSR_STEP_TIME   = 1'b1
   } csr_index_type;

   // atan(2^-i) in degrees, Q.16
   function automatic logic signed [23:0] atan_deg(input logic [4:0] idx);
      logic signed [23:0] v;
      unique case (idx)
         5'd0:  v = 24'sd2949120;
         5'd1:  v = 24'sd1740967;
         5'd2:  v = 24'sd919879;
         5'd3:  v = 24'sd466945;
         5'd4:  v = 24'sd234379;
         5'd5:  v = 24'sd117304;
         5'd6:  v = 24'sd58666;
         5'd7:  v = 24'sd29335;
         5'd8:  v = 24'sd14668;
         5'd9:  v = 24'sd7334;
         5'd10: v = 24'sd3667;
         5'd11: v = 24'sd1833;
         5'd12: v = 24'sd917;
         5'd13: v = 24'sd458;
         5'd14: v = 24'sd229;
         5'd15: v = 24'sd115;
         5'd16: v = 24'sd57;
         5'd17: v = 24'sd29;
         5'd18: v = 24'sd14;
         5'd19: v = 24'sd7;
         5'd20: v = 24'sd4;
         5'd21: v = 24'sd2;
         5'd22: v = 24'sd1;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/core/ctf_req_if.sv
interface ctf_req_if import ctf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [CTF_IN_W-1:0] gyro_x_rate;
   logic signed [CTF_IN_W-1:0] gyro_y_rate;
   logic signed [CTF_IN_W-1:0] accel_x;
   logic signed [CTF_IN_W-1:0] accel_y;
   logic signed [CTF_IN_W-1:0] accel_z;

   modport source (output valid, gyro_x_rate, gyro_y_rate, accel_x, accel_y, accel_z,
                   input ready);
   modport sink (input valid, gyro_x_rate, gyro_y_rate, accel_x, accel_y, accel_z,
                 output ready);
endinterface

>>> rtl/core/ctf_rsp_if.sv
interface ctf_rsp_if import ctf_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [CTF_OUT_W-1:0] roll_angle;
   logic signed [CTF_OUT_W-1:0] pitch_angle;

   modport source (output valid, roll_angle, pitch_angle, input ready);
   modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

>>> rtl/core/complementary_tilt_filter.sv
// A new beat is accepted only in the idle state, one beat at a time; the shared
// shift-add multiplier (one bit per cycle), the bit-pair square root and CORDIC are reused.
// A finished result waits in the output register while the next beat is taken; each rounding
// step of that beat stalls until the waiting result is accepted.
// Reset (synchronous, active high): angles to zero, weight 0.8, step 0.001 s, idle.
module complementary_tilt_filter import ctf_pkg::*; #(
   parameter int CORDIC_STEPS = CTF_CORDIC_STEPS
) (
   input  logic                 clock,
   input  logic                 reset,
   ctf_req_if.sink              req_chan,
   ctf_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [0:0]           csr_index,
   input  logic [CTF_CSR_W-1:0] csr_wr_data
);

`include "complementary_tilt_filter_assert.svh"

   localparam int CntW  = ($clog2(CORDIC_STEPS) > 5) ? $clog2(CORDIC_STEPS) : 5;
   localparam int AccW  = 60;
   localparam int CordW = 32;
   localparam logic [CntW-1:0] CordLast = CntW'(CORDIC_STEPS - 1);
   localparam logic [CntW-1:0] Last16   = CntW'(15);
   localparam logic [CntW-1:0] Last17   = CntW'(16);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SQ_Y  = 9'b000000010,
      S_SQ_Z  = 9'b000000100,
      S_SQRT  = 9'b000001000,
      S_CORD  = 9'b000010000,
      S_RATE  = 9'b000100000,
      S_WGT   = 9'b001000000,
      S_ACC   = 9'b010000000,
      S_ROUND = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   logic signed [CTF_IN_W-1:0] gx_ff, gy_ff, ax_ff, ay_ff, az_ff;
   logic signed [CTF_IN_W-1:0] gx_in, gy_in, ax_in, ay_in, az_in;
   logic [CTF_WEIGHT_W-1:0] weight_ff;
   logic [CTF_STEP_W-1:0]   step_ff;

   // shift-add multiplier
   logic signed [AccW-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [16:0]            mplier_ff, mplier_in;
   logic                   msigned_ff, msigned_in;
   logic [CntW-1:0]        mlast_ff, mlast_in;
   logic signed [AccW-1:0] mul_add, acc_step;
   logic                   mul_done;

   // square root
   logic [31:0] sqv_ff, sqv_in, sqres_ff, sqres_in, sqbit_ff, sqbit_in;
   logic [32:0] sq_try;

   // CORDIC
   logic signed [CordW-1:0] cx_ff, cx_in, cy_ff, cy_in, cxs, cys, cx_step, cy_step;
   logic signed [23:0]      cz_ff, cz_in, cz_step, cord_atan;
   logic signed [23:0]      roll_acc_ff, roll_acc_in, pitch_acc_ff, pitch_acc_in;

   // setup values
   logic [15:0]             abs_ay_req, abs_az;
   logic signed [16:0]      ay17, az17, roll_x17, roll_y17;
   logic signed [23:0]      spec_roll, spec_pitch, acc_q16;
   logic signed [AccW-1:0]  acc_wide;
   logic signed [16:0]      wcomp;

   // rounding
   logic signed [AccW-1:0]      rsum, rshift;
   logic signed [24:0]          rq;
   logic signed [CTF_OUT_W-1:0] rsat;
   logic signed [CTF_OUT_W-1:0] roll_est_ff, roll_est_in, pitch_est_ff, pitch_est_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // magnitudes for squaring, and the sign-folded roll vector for CORDIC
   always_comb begin
      ay17       = {ay_ff[15], ay_ff};
      az17       = {az_ff[15], az_ff};
      abs_ay_req = req_chan.accel_y[15] ? 16'(-req_chan.accel_y) : 16'(req_chan.accel_y);
      abs_az     = az_ff[15] ? 16'(-az17) : 16'(az17);
      roll_x17   = az_ff[15] ? -az17 : az17;
      roll_y17   = az_ff[15] ? -ay17 : ay17;
   end

   // multiplier step: sign bit of a signed multiplier carries negative weight
   always_comb begin
      mul_done = (cnt_ff == mlast_ff);
      if (mplier_ff[0]) begin
         mul_add = (msigned_ff && mul_done) ? -mcand_ff : mcand_ff;
      end else begin
         mul_add = '0;
      end
      acc_step = acc_ff + mul_add;
   end

   // square root step
   assign sq_try = {1'b0, sqres_ff} + {1'b0, sqbit_ff};

   // CORDIC step
   always_comb begin
      cxs       = cx_ff >>> cnt_ff;
      cys       = cy_ff >>> cnt_ff;
      cord_atan = atan_deg(cnt_ff[4:0]);
      if (!cy_ff[CordW-1]) begin
         cx_step = cx_ff + cys;
         cy_step = cy_ff - cxs;
         cz_step = cz_ff + cord_atan;
      end else begin
         cx_step = cx_ff - cys;
         cy_step = cy_ff + cxs;
         cz_step = cz_ff - cord_atan;
      end
   end

   // fixed angles where the arctangent has no denominator
   always_comb begin
      if (ay_ff > 0)      spec_roll = CTF_NINETY_Q16;
      else if (ay_ff < 0) spec_roll = -CTF_NINETY_Q16;
      else                spec_roll = '0;
      if (ax_ff > 0)      spec_pitch = CTF_NINETY_Q16;
      else if (ax_ff < 0) spec_pitch = -CTF_NINETY_Q16;
      else                spec_pitch = '0;
   end

   // accelerometer term and (1 - w)
   always_comb begin
      acc_q16  = axis_ff ? pitch_acc_ff : roll_acc_ff;
      acc_wide = {{(AccW-36){acc_q16[23]}}, acc_q16, 12'd0};
      wcomp    = 17'(CTF_WEIGHT_ONE - {1'b0, weight_ff});
   end

   // round half up at bit 35 and saturate
   always_comb begin
      rsum   = acc_ff + (AccW'(1) <<< 34);
      rshift = rsum >>> 35;
      rq     = rshift[24:0];
      if (rq > 25'(CTF_ANGLE_MAX))       rsat = CTF_ANGLE_MAX;
      else if (rq < -25'(CTF_ANGLE_MAX)) rsat = -CTF_ANGLE_MAX;
      else                               rsat = rq[CTF_OUT_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff + 1'b1;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      msigned_in   = msigned_ff;
      mlast_in     = mlast_ff;
      sqv_in       = sqv_ff;
      sqres_in     = sqres_ff;
      sqbit_in     = sqbit_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      roll_acc_in  = roll_acc_ff;
      pitch_acc_in = pitch_acc_ff;
      roll_est_in  = roll_est_ff;
      pitch_est_in = pitch_est_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_chan.valid) begin
               gx_in      = req_chan.gyro_x_rate;
               gy_in      = req_chan.gyro_y_rate;
               ax_in      = req_chan.accel_x;
               ay_in      = req_chan.accel_y;
               az_in      = req_chan.accel_z;
               acc_in     = '0;
               mcand_in   = AccW'(abs_ay_req);
               mplier_in  = {1'b0, abs_ay_req};
               msigned_in = 1'b0;
               mlast_in   = Last16;
               state_in   = S_SQ_Y;
            end
         end
         S_SQ_Y: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            if (mul_done) begin
               cnt_in    = '0;
               mcand_in  = AccW'(abs_az);
               mplier_in = {1'b0, abs_az};
               state_in  = S_SQ_Z;
            end
         end
         S_SQ_Z: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            if (mul_done) begin
               cnt_in   = '0;
               sqv_in   = acc_step[31:0];
               sqres_in = '0;
               sqbit_in = 32'h4000_0000;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if ({1'b0, sqv_ff} >= sq_try) begin
               sqv_in   = sqv_ff - sq_try[31:0];
               sqres_in = (sqres_ff >> 1) + sqbit_ff;
            end else begin
               sqres_in = sqres_ff >> 1;
            end
            sqbit_in = sqbit_ff >> 2;
            if (cnt_ff == Last16) begin
               // roll CORDIC first
               cnt_in   = '0;
               axis_in  = 1'b0;
               cx_in    = {{3{roll_x17[16]}}, roll_x17, 12'd0};
               cy_in    = {{3{roll_y17[16]}}, roll_y17, 12'd0};
               cz_in    = '0;
               state_in = S_CORD;
            end
         end
         S_CORD: begin
            cx_in = cx_step;
            cy_in = cy_step;
            cz_in = cz_step;
            if (cnt_ff == CordLast) begin
               cnt_in = '0;
               if (!axis_ff) begin
                  roll_acc_in = (az_ff == 0) ? spec_roll : cz_step;
                  axis_in     = 1'b1;
                  cx_in       = {4'd0, sqres_ff[15:0], 12'd0};
                  cy_in       = {{4{ax_ff[15]}}, ax_ff, 12'd0};
                  cz_in       = '0;
               end else begin
                  pitch_acc_in = (sqres_ff == 0) ? spec_pitch : cz_step;
                  // blend roll: start from held angle at Q.28
                  axis_in    = 1'b0;
                  acc_in     = {{(AccW-CTF_OUT_W-20){roll_est_ff[16]}}, roll_est_ff, 20'd0};
                  mcand_in   = AccW'(step_ff);
                  mplier_in  = {1'b0, gx_ff};
                  msigned_in = 1'b1;
                  mlast_in   = Last16;
                  state_in   = S_RATE;
               end
            end
         end
         S_RATE: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            if (mul_done) begin
               cnt_in     = '0;
               acc_in     = '0;
               mcand_in   = acc_step;
               mplier_in  = {1'b0, weight_ff};
               msigned_in = 1'b0;
               state_in   = S_WGT;
            end
         end
         S_WGT: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            if (mul_done) begin
               cnt_in     = '0;
               mcand_in   = axis_ff ? -acc_wide : acc_wide;
               mplier_in  = wcomp;
               msigned_in = 1'b1;
               mlast_in   = Last17;
               state_in   = S_ACC;
            end
         end
         S_ACC: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            if (mul_done) begin
               cnt_in   = '0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cnt_in = '0;
            // angles double as the output register: wait for a pending result
            if (!(rsp_valid_ff && !rsp_chan.ready)) begin
               if (!axis_ff) begin
                  roll_est_in = rsat;
                  axis_in     = 1'b1;
                  acc_in      = {{(AccW-CTF_OUT_W-20){pitch_est_ff[16]}}, pitch_est_ff,
                                 20'd0};
                  mcand_in    = AccW'(step_ff);
                  mplier_in   = {1'b0, gy_ff};
                  msigned_in  = 1'b1;
                  mlast_in    = Last16;
                  state_in    = S_RATE;
               end else begin
                  pitch_est_in = rsat;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         roll_est_ff  <= '0;
         pitch_est_ff <= '0;
         weight_ff    <= CTF_WEIGHT_RESET;
         step_ff      <= CTF_STEP_RESET;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         roll_est_ff  <= roll_est_in;
         pitch_est_ff <= pitch_est_in;
         if (csr_wr_en) begin
            if (csr_index == CSR_GYRO_WEIGHT) weight_ff <= csr_wr_data[CTF_WEIGHT_W-1:0];
            if (csr_index == CSR_STEP_TIME)   step_ff   <= csr_wr_data[CTF_STEP_W-1:0];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      az_ff        <= az_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      msigned_ff   <= msigned_in;
      mlast_ff     <= mlast_in;
      sqv_ff       <= sqv_in;
      sqres_ff     <= sqres_in;
      sqbit_ff     <= sqbit_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      roll_acc_ff  <= roll_acc_in;
      pitch_acc_ff <= pitch_acc_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.roll_angle  = roll_est_ff;
   assign rsp_chan.pitch_angle = pitch_est_ff;

   // checks
   `CTF_ASSERT_NEXT(a_accept_starts, req_chan.valid && req_chan.ready, state_ff == S_SQ_Y, "accepted beat did not start squaring")
   `CTF_ASSERT_NEXT(a_result_held, rsp_valid_ff && !rsp_chan.ready, $stable(roll_est_ff) && $stable(pitch_est_ff), "pending result changed")
   `CTF_ASSERT_IMPLIES(a_angle_range, rsp_valid_ff, roll_est_ff <= CTF_ANGLE_MAX && roll_est_ff >= -CTF_ANGLE_MAX && pitch_est_ff <= CTF_ANGLE_MAX && pitch_est_ff >= -CTF_ANGLE_MAX, "angle out of range")
   `CTF_ASSERT_IMPLIES(a_cordic_index, state_ff == S_CORD, cnt_ff <= CordLast, "CORDIC index past last step")

endmodule
